### rtl/core/cau_pkg.sv
package cau_pkg;

    // Data path sizing.
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int FIELD_W    = 32;
    localparam int SAT_BITS   = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
    localparam int ACC_W      = 66;
    localparam int MAG_W      = 64;
    localparam int QUO_W      = 48;
    localparam int DIV_STEPS  = MAG_W + FRAC_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int EXP_W      = 16;
    localparam int EXP_IDX_W  = $clog2(EXP_W);

    localparam logic signed [ACC_W-1:0] SAT_MAX = (66'sd1 <<< (SAT_BITS - 1)) - 66'sd1;
    localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - 66'sd1;
    localparam logic signed [ACC_W-1:0] HALF    = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ONE_RAW = 66'sd1 <<< FRAC_BITS;
    localparam logic                    ONE_OVF = (ONE_RAW > SAT_MAX);
    localparam logic signed [ACC_W-1:0] ONE_WIDE = ONE_OVF ? SAT_MAX : ONE_RAW;
    localparam logic signed [FIELD_W-1:0] ONE_VAL = ONE_WIDE[FIELD_W-1:0];

    // Operation codes.
    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SUB   = 3'd1,
        CMD_MUL   = 3'd2,
        CMD_DIV   = 3'd3,
        CMD_NEG   = 3'd4,
        CMD_EQUAL = 3'd5,
        CMD_POWER = 3'd6,
        CMD_MAG   = 3'd7
    } t_cmd;

    // Status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_DIVZERO = 2'd1,
        ST_OVF     = 2'd2
    } t_status;

    typedef struct packed {
        logic               ovf;
        logic [FIELD_W-1:0] val;
    } t_sat;

    // Divider result bundle.
    typedef struct packed {
        logic             done;
        logic             big;
        logic [QUO_W-1:0] quo;
    } t_div_res;

    // Clamp a wide signed value to the saturation range.
    function automatic t_sat sat_val(input logic signed [ACC_W-1:0] x);
        t_sat r;
        r.ovf = 1'b0;
        r.val = x[FIELD_W-1:0];
        if (x > SAT_MAX) begin
            r.ovf = 1'b1;
            r.val = SAT_MAX[FIELD_W-1:0];
        end else if (x < SAT_MIN) begin
            r.ovf = 1'b1;
            r.val = SAT_MIN[FIELD_W-1:0];
        end
        return r;
    endfunction

    // Round to nearest with ties upward, then saturate.
    function automatic t_sat round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] s;
        s = (acc + HALF) >>> FRAC_BITS;
        return sat_val(s);
    endfunction

    // Apply a sign to a quotient magnitude and saturate.
    function automatic t_sat sat_quo(input logic neg, input logic big,
                                     input logic [QUO_W-1:0] q);
        logic signed [ACC_W-1:0] m;
        t_sat r;
        m = {{(ACC_W - QUO_W){1'b0}}, q};
        r.ovf = 1'b0;
        if (neg) begin
            if (big || (m > -SAT_MIN)) begin
                r.ovf = 1'b1;
                r.val = SAT_MIN[FIELD_W-1:0];
            end else begin
                r.val = 32'(-m);
            end
        end else begin
            if (big || (m > SAT_MAX)) begin
                r.ovf = 1'b1;
                r.val = SAT_MAX[FIELD_W-1:0];
            end else begin
                r.val = m[FIELD_W-1:0];
            end
        end
        return r;
    endfunction

endpackage

### rtl/core/cau_divider.sv
module cau_divider (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cau_pkg::MAG_W-1:0]   i_mag,
    input  logic [cau_pkg::MAG_W-1:0]   i_den,
    output cau_pkg::t_div_res           o_res
);
    import cau_pkg::*;

    localparam int DV_W = MAG_W + FRAC_BITS;

    logic [MAG_W-1:0]     r_rem;
    logic [DV_W-1:0]      r_dv;
    logic [QUO_W-1:0]     r_quo;
    logic                 r_big;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [MAG_W-1:0]     r_den;

    logic [MAG_W:0]       n_trial;
    logic                 n_ge;
    logic [MAG_W:0]       n_diff;

    // One restoring step per cycle: shift in a dividend bit and try the subtract.
    assign n_trial = {r_rem, r_dv[DV_W-1]};
    assign n_ge    = (n_trial >= {1'b0, r_den});
    assign n_diff  = n_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS);
                r_rem  <= '0;
                r_dv   <= {i_mag, {FRAC_BITS{1'b0}}};
                r_quo  <= '0;
                r_big  <= 1'b0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= n_ge ? n_diff[MAG_W-1:0] : n_trial[MAG_W-1:0];
                r_dv  <= {r_dv[DV_W-2:0], 1'b0};
                r_quo <= {r_quo[QUO_W-2:0], n_ge};
                r_big <= r_big | r_quo[QUO_W-1];
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.big  = r_big;
    assign o_res.quo  = r_quo;

endmodule

### rtl/core/complex_arith_unit.sv
// Channel   | Direction | Handshake          | Payload
// input     | in        | i_valid / o_stall  | i_cmd, i_a_re, i_a_im, i_b_re, i_b_im
// output    | out       | o_valid / i_stall  | o_result_re, o_result_im, o_is_equal, o_status
//
// Add, subtract, negate and compare are registered from the inputs; multiply runs two MAC jobs.
// Divide runs two bit-serial divisions of 80 steps each.
// Magnitude runs 32 steps of the square-root loop.
// Power takes up to 32 complex multiplies on the one multiplier,
// plus one division when the exponent is negative.
// Reset is synchronous; o_stall stays high until the result transaction is taken.
module complex_arith_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [2:0]                    i_cmd,
    input  logic signed [cau_pkg::FIELD_W-1:0] i_a_re,
    input  logic signed [cau_pkg::FIELD_W-1:0] i_a_im,
    input  logic signed [cau_pkg::FIELD_W-1:0] i_b_re,
    input  logic signed [cau_pkg::FIELD_W-1:0] i_b_im,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [cau_pkg::FIELD_W-1:0] o_result_re,
    output logic signed [cau_pkg::FIELD_W-1:0] o_result_im,
    output logic                          o_is_equal,
    output logic [1:0]                    o_status
);
    import cau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MRE, S_MIM, S_DEN, S_NRE, S_DIVRE, S_NIM, S_DIVIM,
        S_MAG, S_SQRT, S_OUT
    } t_state;

    t_state r_state;
    logic [1:0] r_ph;
    t_cmd r_cmd;

    logic signed [FIELD_W-1:0] r_u_re, r_u_im, r_v_re, r_v_im;
    logic signed [FIELD_W-1:0] r_x_re, r_x_im, r_t_re;
    logic signed [63:0]        r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic [MAG_W-1:0]          r_den;
    logic                      r_neg;
    logic                      r_ovf;
    logic [EXP_W-1:0]          r_exp;
    logic [EXP_IDX_W-1:0]      r_idx;
    logic                      r_sub;
    logic [MAG_W-1:0]          r_sq_s, r_sq_res, r_sq_bit;

    logic signed [FIELD_W-1:0] r_out_re, r_out_im;
    logic                      r_out_eq;
    t_status                   r_out_st;

    logic signed [FIELD_W-1:0] m_x1, m_y1, m_x2, m_y2, m_x, m_y;
    logic                      m_minus;
    logic signed [63:0]        m_prod;
    t_sat                      rnd, qs, sq_sat;
    logic signed [ACC_W-1:0]   acc_abs;
    logic                      div_start;
    t_div_res                  div_res;
    logic [MAG_W-1:0]          sq_try;
    logic [FIELD_W-1:0]        b_abs, e_full;
    logic                      exp_neg;
    t_sat                      s_add_re, s_add_im, s_sub_re, s_sub_im, s_neg_re, s_neg_im;

    // Operand pairs for the two products of each multiply-accumulate job.
    always_comb begin
        m_x1 = r_u_re; m_y1 = r_v_re; m_x2 = r_u_im; m_y2 = r_v_im; m_minus = 1'b0;
        unique case (r_state)
            S_MRE: begin m_minus = 1'b1; end
            S_MIM: begin m_y1 = r_v_im; m_y2 = r_v_re; end
            S_DEN: begin m_x1 = r_v_re; m_x2 = r_v_im; end
            S_NRE: begin end
            S_NIM: begin
                m_x1 = r_u_im; m_x2 = r_u_re; m_y2 = r_v_im; m_minus = 1'b1;
            end
            S_MAG: begin m_y1 = r_u_re; m_y2 = r_u_im; end
            default: begin end
        endcase
    end

    // The shared multiplier.
    assign m_x    = (r_ph == 2'd0) ? m_x1 : m_x2;
    assign m_y    = (r_ph == 2'd0) ? m_y1 : m_y2;
    assign m_prod = m_x * m_y;

    assign rnd     = round_sat(r_acc);
    assign acc_abs = r_acc[ACC_W-1] ? -r_acc : r_acc;
    assign div_start = ((r_state == S_NRE) || (r_state == S_NIM)) && (r_ph == 2'd3);
    assign qs      = sat_quo(r_neg, div_res.big, div_res.quo);
    assign sq_try  = r_sq_res + r_sq_bit;
    assign sq_sat  = sat_val(ACC_W'(r_sq_res));

    // Exponent for power: integer part of b_re, rounded toward zero.
    assign b_abs   = i_b_re[FIELD_W-1] ? FIELD_W'(-i_b_re) : i_b_re;
    assign e_full  = b_abs >> FRAC_BITS;
    assign exp_neg = i_b_re[FIELD_W-1] && (e_full != '0);

    // Operations computed combinationally from the inputs.
    assign s_add_re = sat_val(ACC_W'(i_a_re) + ACC_W'(i_b_re));
    assign s_add_im = sat_val(ACC_W'(i_a_im) + ACC_W'(i_b_im));
    assign s_sub_re = sat_val(ACC_W'(i_a_re) - ACC_W'(i_b_re));
    assign s_sub_im = sat_val(ACC_W'(i_a_im) - ACC_W'(i_b_im));
    assign s_neg_re = sat_val(-ACC_W'(i_a_re));
    assign s_neg_im = sat_val(-ACC_W'(i_a_im));

    cau_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (acc_abs[MAG_W-1:0]),
        .i_den   (r_den),
        .o_res   (div_res)
    );

    // Sequencer, data registers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ph    <= '0;
            r_ovf   <= 1'b0;
            r_sub   <= 1'b0;
        end else begin
            // Multiply-accumulate phases shared by every product job.
            if ((r_state == S_MRE) || (r_state == S_MIM) || (r_state == S_DEN) ||
                (r_state == S_NRE) || (r_state == S_NIM) || (r_state == S_MAG)) begin
                r_ph <= r_ph + 2'd1;
                unique case (r_ph)
                    2'd0: r_prod <= m_prod;
                    2'd1: begin
                        r_acc  <= ACC_W'(r_prod);
                        r_prod <= m_prod;
                    end
                    2'd2: r_acc <= m_minus ? r_acc - ACC_W'(r_prod)
                                           : r_acc + ACC_W'(r_prod);
                    default: begin end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd    <= t_cmd'(i_cmd);
                        r_ovf    <= 1'b0;
                        r_ph     <= '0;
                        r_sub    <= 1'b0;
                        r_out_re <= '0;
                        r_out_im <= '0;
                        r_out_eq <= 1'b0;
                        r_out_st <= ST_OK;
                        r_u_re   <= i_a_re;
                        r_u_im   <= i_a_im;
                        r_v_re   <= i_b_re;
                        r_v_im   <= i_b_im;
                        r_exp    <= e_full[EXP_W-1:0];
                        r_idx    <= EXP_IDX_W'(EXP_W - 1);
                        unique case (t_cmd'(i_cmd))
                            CMD_ADD: begin
                                r_out_re <= s_add_re.val;
                                r_out_im <= s_add_im.val;
                                r_out_st <= (s_add_re.ovf | s_add_im.ovf) ? ST_OVF : ST_OK;
                                r_state  <= S_OUT;
                            end
                            CMD_SUB: begin
                                r_out_re <= s_sub_re.val;
                                r_out_im <= s_sub_im.val;
                                r_out_st <= (s_sub_re.ovf | s_sub_im.ovf) ? ST_OVF : ST_OK;
                                r_state  <= S_OUT;
                            end
                            CMD_NEG: begin
                                r_out_re <= s_neg_re.val;
                                r_out_im <= s_neg_im.val;
                                r_out_st <= (s_neg_re.ovf | s_neg_im.ovf) ? ST_OVF : ST_OK;
                                r_state  <= S_OUT;
                            end
                            CMD_EQUAL: begin
                                r_out_eq <= (i_a_re == i_b_re) && (i_a_im == i_b_im);
                                r_state  <= S_OUT;
                            end
                            CMD_MUL: r_state <= S_MRE;
                            CMD_DIV: r_state <= S_DEN;
                            CMD_MAG: r_state <= S_MAG;
                            CMD_POWER: begin
                                r_ovf <= ONE_OVF;
                                if (exp_neg) begin
                                    if ((i_a_re == '0) && (i_a_im == '0)) begin
                                        r_out_st <= ST_DIVZERO;
                                        r_state  <= S_OUT;
                                    end else begin
                                        // Reciprocal of a first.
                                        r_u_re  <= ONE_VAL;
                                        r_u_im  <= '0;
                                        r_v_re  <= i_a_re;
                                        r_v_im  <= i_a_im;
                                        r_state <= S_DEN;
                                    end
                                end else begin
                                    r_x_re  <= i_a_re;
                                    r_x_im  <= i_a_im;
                                    r_u_re  <= ONE_VAL;
                                    r_u_im  <= '0;
                                    r_v_re  <= ONE_VAL;
                                    r_v_im  <= '0;
                                    r_state <= S_MRE;
                                end
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end

                S_MRE: begin
                    if (r_ph == 2'd3) begin
                        r_t_re  <= rnd.val;
                        r_ovf   <= r_ovf | rnd.ovf;
                        r_state <= S_MIM;
                    end
                end

                S_MIM: begin
                    if (r_ph == 2'd3) begin
                        if (r_cmd == CMD_POWER) begin
                            r_ovf <= r_ovf | rnd.ovf;
                            r_u_re <= r_t_re;
                            r_u_im <= rnd.val;
                            if (!r_sub && r_exp[r_idx]) begin
                                // Multiply the squared value by the base.
                                r_sub   <= 1'b1;
                                r_v_re  <= r_x_re;
                                r_v_im  <= r_x_im;
                                r_state <= S_MRE;
                            end else begin
                                r_sub  <= 1'b0;
                                r_v_re <= r_t_re;
                                r_v_im <= rnd.val;
                                if (r_idx == '0) begin
                                    r_out_re <= r_t_re;
                                    r_out_im <= rnd.val;
                                    r_out_st <= (r_ovf | rnd.ovf) ? ST_OVF : ST_OK;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_idx   <= r_idx - 1'b1;
                                    r_state <= S_MRE;
                                end
                            end
                        end else begin
                            r_out_re <= r_t_re;
                            r_out_im <= rnd.val;
                            r_out_st <= (r_ovf | rnd.ovf) ? ST_OVF : ST_OK;
                            r_state  <= S_OUT;
                        end
                    end
                end

                S_DEN: begin
                    if (r_ph == 2'd3) begin
                        r_den <= r_acc[MAG_W-1:0];
                        if (r_acc == '0) begin
                            r_out_st <= ST_DIVZERO;
                            r_state  <= S_OUT;
                        end else begin
                            r_state <= S_NRE;
                        end
                    end
                end

                S_NRE: begin
                    if (r_ph == 2'd3) begin
                        r_neg   <= r_acc[ACC_W-1];
                        r_state <= S_DIVRE;
                    end
                end

                S_DIVRE: begin
                    if (div_res.done) begin
                        r_t_re  <= qs.val;
                        r_ovf   <= r_ovf | qs.ovf;
                        r_state <= S_NIM;
                    end
                end

                S_NIM: begin
                    if (r_ph == 2'd3) begin
                        r_neg   <= r_acc[ACC_W-1];
                        r_state <= S_DIVIM;
                    end
                end

                S_DIVIM: begin
                    if (div_res.done) begin
                        r_ovf <= r_ovf | qs.ovf;
                        if (r_cmd == CMD_POWER) begin
                            // Reciprocal done: it becomes the base.
                            r_x_re  <= r_t_re;
                            r_x_im  <= qs.val;
                            r_u_re  <= ONE_VAL;
                            r_u_im  <= '0;
                            r_v_re  <= ONE_VAL;
                            r_v_im  <= '0;
                            r_state <= S_MRE;
                        end else begin
                            r_out_re <= r_t_re;
                            r_out_im <= qs.val;
                            r_out_st <= (r_ovf | qs.ovf) ? ST_OVF : ST_OK;
                            r_state  <= S_OUT;
                        end
                    end
                end

                S_MAG: begin
                    if (r_ph == 2'd3) begin
                        r_sq_s   <= r_acc[MAG_W-1:0];
                        r_sq_res <= '0;
                        r_sq_bit <= MAG_W'(1) << (MAG_W - 2);
                        r_state  <= S_SQRT;
                    end
                end

                S_SQRT: begin
                    if (r_sq_bit == '0) begin
                        r_out_re <= sq_sat.val;
                        r_out_st <= sq_sat.ovf ? ST_OVF : ST_OK;
                        r_state  <= S_OUT;
                    end else begin
                        if (r_sq_s >= sq_try) begin
                            r_sq_s   <= r_sq_s - sq_try;
                            r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                        end else begin
                            r_sq_res <= r_sq_res >> 1;
                        end
                        r_sq_bit <= r_sq_bit >> 2;
                    end
                end

                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = (r_state == S_OUT);
    assign o_result_re = r_out_re;
    assign o_result_im = r_out_im;
    assign o_is_equal  = r_out_eq;
    assign o_status    = r_out_st;

    // An accepted transaction keeps the input side closed on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not closed after accept");

    // A pending result always keeps the input side stalled.
    a_valid_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("result pending while input open");

    // A divide-by-zero result carries zero parts.
    a_divzero_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == ST_DIVZERO)) |->
            ((o_result_re == '0) && (o_result_im == '0) && !o_is_equal))
        else $error("divide-by-zero result not cleared");

    // An equal flag only comes with a clean, zero result.
    a_equal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_equal) |->
            ((o_status == ST_OK) && (o_result_re == '0) && (o_result_im == '0)))
        else $error("equal flag with non-zero result");

endmodule

### dv/cau_checker.sv
`timescale 1ns / 100ps

module cau_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic                                o_stall,
    input  logic [2:0]                          i_cmd,
    input  logic signed [cau_pkg::FIELD_W-1:0]  i_a_re,
    input  logic signed [cau_pkg::FIELD_W-1:0]  i_a_im,
    input  logic signed [cau_pkg::FIELD_W-1:0]  i_b_re,
    input  logic signed [cau_pkg::FIELD_W-1:0]  i_b_im,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic signed [cau_pkg::FIELD_W-1:0]  o_result_re,
    input  logic signed [cau_pkg::FIELD_W-1:0]  o_result_im,
    input  logic                                o_is_equal,
    input  logic [1:0]                          o_status,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import cau_pkg::*;

    localparam longint QMAX = (64'sd1 <<< 31) - 1;
    localparam longint QMIN = -QMAX - 1;
    localparam logic [63:0] QUO_CAP = 64'd1 << 40;
    localparam logic [63:0] HALF_LSB = 64'd1 << (FRAC_BITS - 1);

    typedef struct {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               eq;
        t_status            st;
    } t_answer;

    t_answer answers_q[$];

    function automatic longint clamp(input longint x, inout bit ovf);
        if (x > QMAX) begin
            ovf = 1'b1;
            return QMAX;
        end
        if (x < QMIN) begin
            ovf = 1'b1;
            return QMIN;
        end
        return x;
    endfunction

    function automatic longint clamp_mag(input bit neg, input logic [63:0] m, inout bit ovf);
        if (!neg) begin
            if (m > 64'(QMAX)) begin
                ovf = 1'b1;
                return QMAX;
            end
            return longint'(m);
        end
        if (m > 64'(QMAX) + 64'd1) begin
            ovf = 1'b1;
            return QMIN;
        end
        return -longint'(m);
    endfunction

    // Exact sum of two products split into sign and magnitude.
    function automatic void add_prods(input longint p, input longint q,
                                      output bit neg, output logic [63:0] mag);
        logic signed [65:0] s;
        s = 66'(p) + 66'(q);
        neg = s < 0;
        mag = neg ? 64'(-s) : 64'(s);
    endfunction

    function automatic longint round_prod(input bit neg, input logic [63:0] mag, inout bit ovf);
        if (!neg) return clamp_mag(1'b0, (mag + HALF_LSB) >> FRAC_BITS, ovf);
        if (mag <= HALF_LSB) return 0;
        return clamp_mag(1'b1, ((mag - HALF_LSB) + ((64'd1 << FRAC_BITS) - 1)) >> FRAC_BITS,
                         ovf);
    endfunction

    function automatic void mul_c(input longint ar, input longint ai, input longint br,
                                  input longint bi, output longint rr, output longint ri,
                                  inout bit ovf);
        bit n;
        logic [63:0] m;
        add_prods(ar * br, -(ai * bi), n, m);
        rr = round_prod(n, m, ovf);
        add_prods(ar * bi, ai * br, n, m);
        ri = round_prod(n, m, ovf);
    endfunction

    // Scaled quotient; anything past the cap saturates regardless.
    function automatic logic [63:0] quot(input logic [63:0] mag, input logic [63:0] d);
        logic [127:0] q;
        q = ({64'd0, mag} << FRAC_BITS) / {64'd0, d};
        return (q >= {64'd0, QUO_CAP}) ? QUO_CAP : q[63:0];
    endfunction

    function automatic bit div_c(input longint ar, input longint ai, input longint br,
                                 input longint bi, output longint rr, output longint ri,
                                 inout bit ovf);
        logic [63:0] d;
        bit n;
        logic [63:0] m;
        d = 64'(br * br) + 64'(bi * bi);
        rr = 0;
        ri = 0;
        if (d == 0) return 1'b0;
        add_prods(ar * br, ai * bi, n, m);
        rr = clamp_mag(n, quot(m, d), ovf);
        add_prods(ai * br, -(ar * bi), n, m);
        ri = clamp_mag(n, quot(m, d), ovf);
        return 1'b1;
    endfunction

    function automatic logic [63:0] root(input logic [63:0] s);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= res + b) begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic t_answer compute(input logic [2:0] cmd, input longint ar,
                                        input longint ai, input longint br, input longint bi);
        t_answer r;
        bit ovf;
        bit err;
        longint rr, ri, n, e, xr, xi;
        logic [63:0] s;
        ovf = 1'b0;
        err = 1'b0;
        rr = 0;
        ri = 0;
        r.eq = 1'b0;
        case (t_cmd'(cmd))
            CMD_ADD: begin
                rr = clamp(ar + br, ovf);
                ri = clamp(ai + bi, ovf);
            end
            CMD_SUB: begin
                rr = clamp(ar - br, ovf);
                ri = clamp(ai - bi, ovf);
            end
            CMD_MUL: mul_c(ar, ai, br, bi, rr, ri, ovf);
            CMD_DIV: err = !div_c(ar, ai, br, bi, rr, ri, ovf);
            CMD_NEG: begin
                rr = clamp(-ar, ovf);
                ri = clamp(-ai, ovf);
            end
            CMD_EQUAL: r.eq = (ar == br) && (ai == bi);
            CMD_POWER: begin
                n = (br >= 0) ? (br >>> FRAC_BITS) : -((-br) >>> FRAC_BITS);
                xr = ar;
                xi = ai;
                e = n;
                if (n < 0) begin
                    if (ar == 0 && ai == 0) err = 1'b1;
                    else void'(div_c(64'd1 << FRAC_BITS, 0, ar, ai, xr, xi, ovf));
                    e = -n;
                end
                if (!err) begin
                    rr = 64'd1 << FRAC_BITS;
                    ri = 0;
                    for (int i = 15; i >= 0; i--) begin
                        mul_c(rr, ri, rr, ri, rr, ri, ovf);
                        if (e[i]) mul_c(rr, ri, xr, xi, rr, ri, ovf);
                    end
                end
            end
            default: begin
                s = 64'(ar * ar) + 64'(ai * ai);
                rr = clamp_mag(1'b0, root(s), ovf);
            end
        endcase
        r.re = rr[31:0];
        r.im = ri[31:0];
        r.st = ST_OK;
        if (err) begin
            r.re = 0;
            r.im = 0;
            r.eq = 1'b0;
            r.st = ST_DIVZERO;
        end else if (ovf) begin
            r.st = ST_OVF;
        end
        return r;
    endfunction

    assign o_pending = answers_q.size();

    // Predict on each accepted input transaction, compare each accepted result.
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && i_valid && !o_stall) begin
            answers_q.push_back(compute(i_cmd, i_a_re, i_a_im, i_b_re, i_b_im));
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (answers_q.size() == 0) begin
                $error("result transaction with nothing expected");
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = answers_q.pop_front();
                if (o_result_re !== want.re) begin
                    $error("result_re expected %0d actual %0d", want.re, o_result_re);
                    o_fail_count <= o_fail_count + 1;
                end
                if (o_result_im !== want.im) begin
                    $error("result_im expected %0d actual %0d", want.im, o_result_im);
                    o_fail_count <= o_fail_count + 1;
                end
                if (o_is_equal !== want.eq) begin
                    $error("is_equal expected %0d actual %0d", want.eq, o_is_equal);
                    o_fail_count <= o_fail_count + 1;
                end
                if (o_status !== want.st) begin
                    $error("status expected %0d actual %0d", want.st, o_status);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end

    initial o_fail_count = 0;

endmodule

### dv/tb_complex_arith_unit.sv
`timescale 1ns / 100ps

module tb_complex_arith_unit;
    import cau_pkg::*;

    localparam int RANDOM_ITEMS = 1380;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam int DRAIN_CYCLES = 1000;
    localparam logic signed [31:0] MAXV = 32'sh7fffffff;
    localparam logic signed [31:0] MINV = 32'sh80000000;
    localparam logic signed [31:0] ONE  = 32'sh00010000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [2:0]         i_cmd;
    logic signed [31:0] i_a_re, i_a_im, i_b_re, i_b_im;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_result_re, o_result_im;
    logic               o_is_equal;
    logic [1:0]         o_status;
    int                 fail_count;
    int                 pending;
    int                 cycles;
    bit                 hold_rx;

    complex_arith_unit dut (.*);

    cau_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_cmd(i_cmd), .i_a_re(i_a_re), .i_a_im(i_a_im), .i_b_re(i_b_re), .i_b_im(i_b_im),
        .o_valid(o_valid), .i_stall(i_stall), .o_result_re(o_result_re),
        .o_result_im(o_result_im), .o_is_equal(o_is_equal), .o_status(o_status),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Operand part drawn from a spread of magnitudes.
    function automatic logic signed [31:0] pick_part();
        int k;
        k = $urandom_range(0, 9);
        case (k)
            0, 1, 2: return $urandom();
            3, 4, 5, 6: return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
            7: return MAXV;
            8: return MINV;
            default: return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
        endcase
    endfunction

    // Send one input transaction and wait until it is taken.
    task automatic send(input t_cmd cmd, input logic signed [31:0] ar,
                        input logic signed [31:0] ai, input logic signed [31:0] br,
                        input logic signed [31:0] bi);
        int g;
        i_valid <= 1'b1;
        i_cmd   <= cmd;
        i_a_re  <= ar;
        i_a_im  <= ai;
        i_b_re  <= br;
        i_b_im  <= bi;
        do @(posedge i_clk); while (!(i_valid && !o_stall));
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Receiver back-pressure, with one long hold-off on request.
    initial begin
        int k;
        i_stall <= 1'b0;
        forever begin
            if (hold_rx) begin
                i_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                hold_rx = 1'b0;
            end else begin
                k = $urandom_range(0, 99);
                i_stall <= (k < 25);
                if (k == 0) repeat ($urandom_range(20, 80)) @(posedge i_clk);
                else @(posedge i_clk);
            end
        end
    end

    initial begin
        logic signed [31:0] ar, ai, br, bi;
        t_cmd cmd;
        int k;
        cycles = 0;
        hold_rx = 1'b0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_cmd   <= CMD_ADD;
        i_a_re  <= 0;
        i_a_im  <= 0;
        i_b_re  <= 0;
        i_b_im  <= 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed cases: extremes, every operation and the corner cases.
        send(CMD_ADD, MAXV, MINV, MAXV, MINV);
        send(CMD_ADD, 32'sd5, -32'sd7, 32'sd11, 32'sd3);
        send(CMD_SUB, MINV, MAXV, MAXV, MINV);
        send(CMD_SUB, 32'sd0, 32'sd0, -32'sd1, -32'sd1);
        send(CMD_MUL, ONE, ONE, ONE, -ONE);
        send(CMD_MUL, MAXV, MINV, MAXV, MAXV);
        send(CMD_MUL, MINV, MINV, MINV, MINV);
        send(CMD_MUL, 32'sd1, 32'sd0, 32'sd32768, 32'sd0);
        send(CMD_MUL, -32'sd1, 32'sd0, 32'sd32768, 32'sd0);
        send(CMD_DIV, ONE, ONE, 32'sd0, 32'sd0);
        send(CMD_DIV, 32'sd3 * ONE, -ONE, ONE, ONE);
        send(CMD_DIV, MAXV, MINV, 32'sd1, 32'sd0);
        send(CMD_DIV, MINV, MINV, MINV, MINV);
        send(CMD_NEG, MINV, MAXV, 32'sd0, 32'sd0);
        send(CMD_NEG, 32'sd1234, -32'sd1, 32'sd0, 32'sd0);
        send(CMD_EQUAL, 32'sd77, -32'sd5, 32'sd77, -32'sd5);
        send(CMD_EQUAL, 32'sd77, -32'sd5, 32'sd77, -32'sd4);
        send(CMD_POWER, 32'sd0, 32'sd0, 32'sd0, 32'sd0);
        send(CMD_POWER, 32'sd0, 32'sd0, -ONE, 32'sd0);
        send(CMD_POWER, ONE, ONE, 32'sd5 * ONE, 32'sd0);
        send(CMD_POWER, ONE, -ONE, -32'sd3 * ONE - 32'sd7, 32'sd0);
        send(CMD_POWER, 32'sd2 * ONE, 32'sd0, MAXV, 32'sd0);
        send(CMD_POWER, ONE, ONE, MINV, MAXV);
        send(CMD_MAG, MAXV, MINV, 32'sd0, 32'sd0);
        send(CMD_MAG, MINV, MINV, 32'sd0, 32'sd0);

        // Random transactions with a long receiver hold-off and a full drain.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 400) hold_rx = 1'b1;
            if (n == 800) begin
                @(negedge i_clk);
                wait (pending == 0);
            end
            cmd = t_cmd'($urandom_range(0, 7));
            ar = pick_part();
            ai = pick_part();
            br = pick_part();
            bi = pick_part();
            k = $urandom_range(0, 9);
            if (cmd == CMD_EQUAL && k < 5) begin
                br = ar;
                bi = ai;
                if (k == 0) bi = ai ^ (32'sd1 <<< $urandom_range(0, 31));
            end
            if (cmd == CMD_POWER && k < 8) begin
                ar = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
                ai = $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
                br = ($signed($urandom_range(0, 16)) - 32'sd8) * ONE
                     + $signed($urandom_range(0, 32'hffff));
                if (k == 0) begin
                    ar = 0;
                    ai = 0;
                end
            end
            if (cmd == CMD_DIV && k == 0) begin
                br = 0;
                bi = 0;
            end
            send(cmd, ar, ai, br, bi);
        end
        i_valid <= 1'b0;

        @(negedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
